FILE: design/presence_sitting_reminder_fsm_macros.svh
// Assertion helpers used by the checker file psr_checker.sv.
`ifndef PRESENCE_SITTING_REMINDER_FSM_MACROS_SVH
`define PRESENCE_SITTING_REMINDER_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psr check failed");

// Next-cycle implication, disabled while reset is low.
`define PSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psr check failed");

// Next-cycle implication that also holds across reset.
`define PSR_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("psr reset check failed");

`endif

FILE: design/psr_pkg.sv
package psr_pkg;

  typedef enum logic [1:0] {
    MODE_MONITOR = 2'd0,
    MODE_SIT     = 2'd1,
    MODE_AWAY    = 2'd2,
    MODE_ALERT   = 2'd3
  } psr_mode_t;

  localparam logic        CFG_IDX_CODE     = 1'b0;
  localparam logic        CFG_IDX_GAP      = 1'b1;
  localparam logic [31:0] GAP_RESET        = 32'd30000;
  localparam logic [31:0] AWAY_LIMIT_MS    = 32'd20000;
  localparam logic [31:0] ALERT_TIMEOUT_MS = 32'd10000;
  localparam logic [1:0]  TALLY_MAX        = 2'd3;
  localparam logic [3:0]  CODE_FIRST       = 4'd1;
  localparam logic [3:0]  CODE_LAST        = 4'd14;
  localparam logic [3:0]  WATER_CODE_FIRST = 4'd5;
  localparam logic        OP_TICK          = 1'b0;

  typedef struct packed {
    logic [31:0] now_ms;
    psr_mode_t   mode;
    logic [31:0] sit_begin;
    logic [31:0] away_begin;
    logic [1:0]  tally;
    logic        absent;
    logic [31:0] absence_begin;
  } psr_state_t;

  typedef struct packed {
    logic sitting_alert;
    logic water_alert;
    logic leave_chime;
    logic return_chime;
  } psr_flags_t;

  // Sitting limit in ticks for each reminder code.
  function automatic logic [31:0] sit_limit(input logic [3:0] code);
    logic [31:0] lim;
    case (code)
      4'd1:    lim = 32'd60000;
      4'd2:    lim = 32'd600000;
      4'd3:    lim = 32'd1800000;
      4'd4:    lim = 32'd3600000;
      4'd5:    lim = 32'd7200000;
      4'd6:    lim = 32'd600000;
      4'd7:    lim = 32'd1200000;
      4'd8:    lim = 32'd1800000;
      4'd9:    lim = 32'd3600000;
      4'd10:   lim = 32'd10000;
      4'd11:   lim = 32'd20000;
      4'd12:   lim = 32'd30000;
      4'd13:   lim = 32'd40000;
      4'd14:   lim = 32'd50000;
      default: lim = 32'd0;
    endcase
    return lim;
  endfunction

endpackage

FILE: design/psr_if.sv
interface psr_in_if;
  logic valid;
  logic ready;
  logic op;
  logic presence;
  logic restart;

  modport source (output valid, op, presence, restart, input ready);
  modport sink   (input valid, op, presence, restart, output ready);
endinterface

interface psr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] state_code;
  logic       sitting_alert;
  logic       water_alert;
  logic       leave_chime;
  logic       return_chime;
  logic [1:0] alerts_so_far;

  modport source (output valid, state_code, sitting_alert, water_alert, leave_chime,
                  return_chime, alerts_so_far, input ready);
  modport sink   (input valid, state_code, sitting_alert, water_alert, leave_chime,
                  return_chime, alerts_so_far, output ready);
endinterface

FILE: design/psr_step.sv
module psr_step (
  input  psr_pkg::psr_state_t cur,
  input  logic [3:0]          code,
  input  logic [31:0]         gap_ms,
  input  logic                op,
  input  logic                presence,
  input  logic                restart,
  output psr_pkg::psr_state_t nxt,
  output psr_pkg::psr_flags_t flags
);

  logic        enabled;
  logic        skip;
  logic [31:0] t;
  logic [31:0] sit_elapsed;
  logic [31:0] away_elapsed;
  logic [31:0] abs_elapsed;
  logic [31:0] limit;

  assign enabled = (code >= psr_pkg::CODE_FIRST) && (code <= psr_pkg::CODE_LAST);
  assign limit   = psr_pkg::sit_limit(code);
  assign t       = cur.now_ms;

  always_comb begin
    nxt   = cur;
    flags = '0;
    skip  = 1'b0;

    // restart clears the machine, or drops the whole poll when reminders are off
    if (restart) begin
      if (enabled) begin
        nxt.mode       = psr_pkg::MODE_MONITOR;
        nxt.sit_begin  = '0;
        nxt.away_begin = '0;
        nxt.tally      = '0;
      end else begin
        skip = 1'b1;
      end
    end

    sit_elapsed  = t - nxt.sit_begin;
    away_elapsed = t - nxt.away_begin;
    abs_elapsed  = t - cur.absence_begin;

    if (op == psr_pkg::OP_TICK) begin
      nxt.now_ms = cur.now_ms + 32'd1;
    end else if (!skip) begin
      if (enabled) begin
        case (nxt.mode)
          psr_pkg::MODE_MONITOR: begin
            if (presence) begin
              nxt.sit_begin = t;
              nxt.mode      = psr_pkg::MODE_SIT;
            end
          end
          psr_pkg::MODE_SIT: begin
            if (!presence) begin
              nxt.away_begin = t;
              nxt.mode       = psr_pkg::MODE_AWAY;
            end else if (sit_elapsed >= limit) begin
              if (code < psr_pkg::WATER_CODE_FIRST) begin
                flags.sitting_alert = 1'b1;
              end else begin
                flags.water_alert = 1'b1;
              end
              nxt.mode = psr_pkg::MODE_ALERT;
              if (nxt.tally < psr_pkg::TALLY_MAX) begin
                nxt.tally = nxt.tally + 2'd1;
              end
            end
          end
          psr_pkg::MODE_AWAY: begin
            if (presence) begin
              nxt.mode = psr_pkg::MODE_SIT;
            end else if (away_elapsed >= psr_pkg::AWAY_LIMIT_MS) begin
              nxt.sit_begin = '0;
              nxt.mode      = psr_pkg::MODE_MONITOR;
            end
          end
          psr_pkg::MODE_ALERT: begin
            if (!presence) begin
              flags.leave_chime = 1'b1;
              nxt.mode          = psr_pkg::MODE_MONITOR;
              nxt.tally         = '0;
            end else if (sit_elapsed > psr_pkg::ALERT_TIMEOUT_MS) begin
              nxt.mode = psr_pkg::MODE_MONITOR;
            end
            if (nxt.tally >= psr_pkg::TALLY_MAX) begin
              nxt.mode  = psr_pkg::MODE_MONITOR;
              nxt.tally = '0;
            end
          end
          default: begin
            nxt.mode = psr_pkg::MODE_MONITOR;
          end
        endcase
      end

      // absence tracker runs whether or not reminders are on
      if (!presence && !cur.absent) begin
        nxt.absence_begin = t;
        nxt.absent        = 1'b1;
      end else if (presence && cur.absent) begin
        flags.return_chime = (abs_elapsed > gap_ms);
        nxt.absent         = 1'b0;
      end
    end
  end

endmodule

FILE: design/presence_sitting_reminder_fsm.sv
// Sitting and water reminder controller.
//
// in_ch carries one item per tick or sensor poll: op (0 tick, 1 poll), the
// presence sample and a restart flag. out_ch returns exactly one result item
// per input item: the machine state after the step, the alert, leave and
// return flags, and the alert count.
// cfg_we/cfg_index/cfg_wdata write the reminder code (index 0, low four
// bits) or the presence gap in ticks (index 1); write only while idle.
//
// An accepted item goes through the input register and then the result
// register to out_ch. Throughput: one item per cycle while out_ch does not
// stall. The whole state update is one pass of combinational logic between
// the two registers, so each item sees the state its predecessor left.
//
// Reset (rst_n low, synchronous) empties both registers, clears the time
// counter and machine, and loads reminder code 0 and a gap of 30000 ticks.
// When the receiver stalls, the result register holds its item and the
// input register holds one more; in_ch.ready drops only when both are full.
module presence_sitting_reminder_fsm (
  input  logic             clk,
  input  logic             rst_n,
  psr_in_if.sink           in_ch,
  psr_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_wdata
);

  // configuration
  logic [3:0]  code_r;
  logic [31:0] gap_r;

  // input register
  logic s1_valid_r;
  logic s1_op_r;
  logic s1_presence_r;
  logic s1_restart_r;

  // state and result register
  psr_pkg::psr_state_t state_r;
  psr_pkg::psr_state_t state_nxt;
  psr_pkg::psr_flags_t flags_nxt;
  psr_pkg::psr_flags_t flags_r;
  logic                out_valid_r;
  logic [1:0]          mode_r;
  logic [1:0]          tally_r;

  logic advance;
  logic in_take;

  // move the held item forward whenever the result slot is free or draining
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= 4'd0;
      gap_r  <= psr_pkg::GAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == psr_pkg::CFG_IDX_CODE) begin
        code_r <= cfg_wdata[3:0];
      end else begin
        gap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r       <= in_ch.op;
      s1_presence_r <= in_ch.presence;
      s1_restart_r  <= in_ch.restart;
    end
  end

  psr_step u_step (
    .cur      (state_r),
    .code     (code_r),
    .gap_ms   (gap_r),
    .op       (s1_op_r),
    .presence (s1_presence_r),
    .restart  (s1_restart_r),
    .nxt      (state_nxt),
    .flags    (flags_nxt)
  );

  // commit the state exactly when the item reaches the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{now_ms: '0, mode: psr_pkg::MODE_MONITOR, sit_begin: '0,
                   away_begin: '0, tally: '0, absent: 1'b0, absence_begin: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags_r <= flags_nxt;
      mode_r  <= state_nxt.mode;
      tally_r <= state_nxt.tally;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.state_code    = mode_r;
  assign out_ch.sitting_alert = flags_r.sitting_alert;
  assign out_ch.water_alert   = flags_r.water_alert;
  assign out_ch.leave_chime   = flags_r.leave_chime;
  assign out_ch.return_chime  = flags_r.return_chime;
  assign out_ch.alerts_so_far = tally_r;

endmodule

FILE: design/psr_checker.sv
`include "presence_sitting_reminder_fsm_macros.svh"

module psr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] state_code,
  input logic       sitting_alert,
  input logic       water_alert,
  input logic       leave_chime,
  input logic [1:0] alerts_so_far
);

  `PSR_ASSERT_RST(a_reset_empties, !rst_n, !out_valid)
  `PSR_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid)
  `PSR_ASSERT_NOW(a_one_kind, out_valid, !(sitting_alert && water_alert))
  `PSR_ASSERT_NOW(a_alert_state, out_valid && (sitting_alert || water_alert),
                  state_code == psr_pkg::MODE_ALERT && alerts_so_far != 2'd0)
  `PSR_ASSERT_NOW(a_leave_clears, out_valid && leave_chime,
                  state_code == psr_pkg::MODE_MONITOR && alerts_so_far == 2'd0)

endmodule

bind presence_sitting_reminder_fsm psr_checker u_psr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .state_code    (out_ch.state_code),
  .sitting_alert (out_ch.sitting_alert),
  .water_alert   (out_ch.water_alert),
  .leave_chime   (out_ch.leave_chime),
  .alerts_so_far (out_ch.alerts_so_far)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // A poll step is the opposite op code to a tick.
  localparam logic OP_POLL     = ~psr_pkg::OP_TICK;
  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int   QUIET_LIMIT = 2000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [1:0] state_code;
    logic       sitting_alert;
    logic       water_alert;
    logic       leave_chime;
    logic       return_chime;
    logic [1:0] alerts;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  psr_in_if  in_ch ();
  psr_out_if out_ch ();

  presence_sitting_reminder_fsm uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Our own copy of the machine, the absence tracker and both registers.
  // It advances when an item is accepted, so it always reflects every item
  // already handed to the block.
  psr_pkg::psr_state_t reminder_state;
  logic [3:0]          code_reg;
  logic [31:0]         gap_reg;

  // Results still owed by the block, oldest first.
  outcome_t pending_outcomes[$];

  int fail_count  = 0;
  int quiet_cycles = 0;
  // Percentage of cycles in which the sender idles and the receiver stalls.
  int idle_pct    = 27;
  int stall_pct   = 27;

  // Sitting limit in ticks for a reminder code; zero where reminders are off.
  function automatic logic [31:0] limit_for_code(input logic [3:0] code);
    case (code)
      4'd1:    return 32'd60_000;
      4'd2:    return 32'd600_000;
      4'd3:    return 32'd1_800_000;
      4'd4:    return 32'd3_600_000;
      4'd5:    return 32'd7_200_000;
      4'd6:    return 32'd600_000;
      4'd7:    return 32'd1_200_000;
      4'd8:    return 32'd1_800_000;
      4'd9:    return 32'd3_600_000;
      4'd10:   return 32'd10_000;
      4'd11:   return 32'd20_000;
      4'd12:   return 32'd30_000;
      4'd13:   return 32'd40_000;
      4'd14:   return 32'd50_000;
      default: return 32'd0;
    endcase
  endfunction

  // Apply one step to our copy of the state and return the result item
  // that the block must produce for it.
  function automatic outcome_t advance_reminder(input logic op, input logic present,
                                                input logic restart);
    outcome_t    res;
    logic        armed;
    logic        skip;
    logic [31:0] t;
    logic [31:0] since_sit;
    logic [31:0] since_away;
    logic [31:0] since_gone;
    res   = '0;
    armed = (code_reg >= psr_pkg::CODE_FIRST) && (code_reg <= psr_pkg::CODE_LAST);
    skip  = 1'b0;

    // A restart clears the machine only with a live code; with reminders off
    // it swallows the rest of a poll, absence tracker included.
    if (restart) begin
      if (armed) begin
        reminder_state.mode       = psr_pkg::MODE_MONITOR;
        reminder_state.sit_begin  = '0;
        reminder_state.away_begin = '0;
        reminder_state.tally      = '0;
      end else begin
        skip = 1'b1;
      end
    end

    if (op == psr_pkg::OP_TICK) begin
      reminder_state.now_ms = reminder_state.now_ms + 32'd1;
    end else if (!skip) begin
      t          = reminder_state.now_ms;
      since_sit  = t - reminder_state.sit_begin;
      since_away = t - reminder_state.away_begin;
      since_gone = t - reminder_state.absence_begin;
      if (armed) begin
        case (reminder_state.mode)
          psr_pkg::MODE_MONITOR: begin
            if (present) begin
              reminder_state.sit_begin = t;
              reminder_state.mode      = psr_pkg::MODE_SIT;
            end
          end
          psr_pkg::MODE_SIT: begin
            if (!present) begin
              reminder_state.away_begin = t;
              reminder_state.mode       = psr_pkg::MODE_AWAY;
            end else if (since_sit >= limit_for_code(code_reg)) begin
              if (code_reg >= psr_pkg::WATER_CODE_FIRST) res.water_alert = 1'b1;
              else res.sitting_alert = 1'b1;
              reminder_state.mode = psr_pkg::MODE_ALERT;
              if (reminder_state.tally < psr_pkg::TALLY_MAX)
                reminder_state.tally = reminder_state.tally + 2'd1;
            end
          end
          psr_pkg::MODE_AWAY: begin
            if (present) begin
              reminder_state.mode = psr_pkg::MODE_SIT;
            end else if (since_away >= psr_pkg::AWAY_LIMIT_MS) begin
              reminder_state.sit_begin = '0;
              reminder_state.mode      = psr_pkg::MODE_MONITOR;
            end
          end
          default: begin
            if (!present) begin
              res.leave_chime      = 1'b1;
              reminder_state.mode  = psr_pkg::MODE_MONITOR;
              reminder_state.tally = '0;
            end else if (since_sit > psr_pkg::ALERT_TIMEOUT_MS) begin
              reminder_state.mode = psr_pkg::MODE_MONITOR;
            end
            // Drop back once the tally has reached its cap.
            if (reminder_state.tally >= psr_pkg::TALLY_MAX) begin
              reminder_state.mode  = psr_pkg::MODE_MONITOR;
              reminder_state.tally = '0;
            end
          end
        endcase
      end
      // The absence tracker runs on every poll, reminders on or off.
      if (!present && !reminder_state.absent) begin
        reminder_state.absence_begin = t;
        reminder_state.absent        = 1'b1;
      end else if (present && reminder_state.absent) begin
        if (since_gone > gap_reg) res.return_chime = 1'b1;
        reminder_state.absent = 1'b0;
      end
    end

    res.state_code = reminder_state.mode;
    res.alerts     = reminder_state.tally;
    return res;
  endfunction

  // Receiver: stall at random, at the rate that stall_pct asks.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // Checker: match every accepted result item against the oldest one owed.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t: result item with nothing owed, expected none actual state %0d",
                   $time, out_ch.state_code);
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("state_code",    want.state_code,    out_ch.state_code);
        compare_field("sitting_alert", want.sitting_alert, out_ch.sitting_alert);
        compare_field("water_alert",   want.water_alert,   out_ch.water_alert);
        compare_field("leave_chime",   want.leave_chime,   out_ch.leave_chime);
        compare_field("return_chime",  want.return_chime,  out_ch.return_chime);
        compare_field("alerts_so_far", want.alerts,        out_ch.alerts_so_far);
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, idling first at random, and hold it until it is taken.
  // Valid is left high on return so that back-to-back items need no second
  // assignment in the same step; settle drops it.
  task automatic send_item(input logic op, input logic present, input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.presence <= present;
    in_ch.restart  <= restart;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_outcomes.push_back(advance_reminder(op, present, restart));
  endtask

  task automatic poll(input logic present);
    send_item(OP_POLL, present, 1'b0);
  endtask

  // Advance the clock of the block by a run of ticks; presence is noise here.
  task automatic send_ticks(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_item(psr_pkg::OP_TICK, 1'($urandom_range(1)), 1'b0);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline run dry.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == psr_pkg::CFG_IDX_CODE) code_reg = value[3:0];
    else gap_reg = value;
  endtask

  // Write a reminder code with junk in the unused upper bits.
  task automatic set_code(input logic [3:0] code);
    logic [31:0] word;
    word      = $urandom();
    word[3:0] = code;
    write_reg(psr_pkg::CFG_IDX_CODE, word);
  endtask

  // Reminders off straight after reset, then with the undefined code: the
  // machine holds, the absence tracker still runs (short absence under the
  // reset gap gives no chime, any absence over a zero gap does), and a
  // restart skips a poll.
  task automatic test_reminders_off();
    poll(1'b1);
    poll(1'b0);
    send_ticks(30);
    poll(1'b1);
    send_item(OP_POLL, 1'b0, 1'b1);
    send_item(psr_pkg::OP_TICK, 1'b1, 1'b1);
    settle();
    set_code(4'd15);
    write_reg(psr_pkg::CFG_IDX_GAP, 32'd0);
    poll(1'b0);
    send_ticks(1);
    poll(1'b1);
    send_item(OP_POLL, 1'b1, 1'b1);
  endtask

  // Sit, step away and come back: away check returns to sitting, and the
  // return chime needs an absence strictly longer than the gap.
  task automatic test_sit_and_away();
    settle();
    set_code(4'd3);
    write_reg(psr_pkg::CFG_IDX_GAP, 32'd5);
    poll(1'b1);
    poll(1'b1);
    poll(1'b0);
    send_ticks(5);
    poll(1'b1);
    poll(1'b0);
    send_ticks(6);
    poll(1'b1);
    send_ticks(2);
    poll(1'b1);
  endtask

  // Restart with a live code while sitting, on polls and on a tick.
  task automatic test_restart();
    settle();
    set_code(4'd11);
    poll(1'b1);
    send_ticks(5);
    send_item(OP_POLL, 1'b1, 1'b1);
    send_item(OP_POLL, 1'b0, 1'b1);
    send_item(psr_pkg::OP_TICK, 1'b0, 1'b1);
    poll(1'b1);
  endtask

  // Polls and ticks flat out with no idling on either side.
  task automatic test_flat_out();
    int k;
    settle();
    set_code(4'd1);
    idle_pct  = 0;
    stall_pct = 0;
    for (k = 0; k < 40; k++) begin
      poll(1'($urandom_range(1)));
      send_ticks(1);
    end
    idle_pct  = 27;
    stall_pct = 27;
  endtask

  // Phases of random traffic, each under a fresh setting. Most steps are
  // polls with a short run of ticks in front; now and then the tick run is
  // stretched to land one tick either side of, or on, the limit that the
  // current state is waiting for, where that limit is within the budget.
  task automatic test_random_traffic();
    logic [3:0]  code;
    logic [31:0] gap;
    logic [31:0] target;
    logic [31:0] elapsed;
    logic [31:0] run;
    logic        has_edge;
    int          phase;
    int          n;
    int          budget;
    for (phase = 0; phase < 8; phase++) begin
      settle();
      case ($urandom_range(7))
        0:       code = 4'd0;
        1:       code = 4'd15;
        2:       code = 4'($urandom_range(9, 1));
        default: code = 4'($urandom_range(14, 10));
      endcase
      if (phase == 0) code = 4'd14;
      case ($urandom_range(4))
        0:       gap = 32'd0;
        1:       gap = $urandom_range(50);
        2:       gap = psr_pkg::GAP_RESET;
        3:       gap = 32'hFFFF_FFFF;
        default: gap = $urandom_range(30, 5);
      endcase
      set_code(code);
      write_reg(psr_pkg::CFG_IDX_GAP, gap);
      // One phase runs with no idling at all.
      idle_pct  = (phase == 3) ? 0 : 27;
      stall_pct = idle_pct;
      // Cap the ticks spent in this phase so the run stays short.
      budget = 60;
      for (n = 0; n < 48; n++) begin
        run      = $urandom_range(3);
        has_edge = 1'b0;
        if ($urandom_range(99) < 6 && budget > 0) begin
          case (reminder_state.mode)
            psr_pkg::MODE_SIT: begin
              target   = limit_for_code(code_reg);
              elapsed  = reminder_state.now_ms - reminder_state.sit_begin;
              has_edge = (target != 0);
            end
            psr_pkg::MODE_AWAY: begin
              target   = psr_pkg::AWAY_LIMIT_MS;
              elapsed  = reminder_state.now_ms - reminder_state.away_begin;
              has_edge = 1'b1;
            end
            psr_pkg::MODE_ALERT: begin
              target   = psr_pkg::ALERT_TIMEOUT_MS;
              elapsed  = reminder_state.now_ms - reminder_state.sit_begin;
              has_edge = 1'b1;
            end
            default: begin
              target   = gap_reg;
              elapsed  = reminder_state.now_ms - reminder_state.absence_begin;
              has_edge = reminder_state.absent;
            end
          endcase
          target = target + $urandom_range(2) - 1;
          if (has_edge && target > elapsed && (target - elapsed) <= budget)
            run = target - elapsed;
        end
        budget -= run;
        send_ticks(run);
        if ($urandom_range(99) < 10)
          send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_item(OP_POLL, $urandom_range(99) < 70, $urandom_range(99) < 3);
      end
    end
    idle_pct  = 27;
    stall_pct = 27;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= psr_pkg::OP_TICK;
    in_ch.presence <= 1'b0;
    in_ch.restart  <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= psr_pkg::CFG_IDX_CODE;
    cfg_wdata      <= '0;

    // Mirror the reset state of the block.
    reminder_state      = '0;
    reminder_state.mode = psr_pkg::MODE_MONITOR;
    code_reg            = 4'd0;
    gap_reg             = psr_pkg::GAP_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reminders_off();
    test_sit_and_away();
    test_restart();
    test_flat_out();
    test_random_traffic();

    // Drain what is owed, then let the pipeline run on before the verdict.
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
